@@ sv/chtih_pkg.sv @@
// Package for the channel time-interval histogram: controller states,
// function codes and fixed field widths.
// No dependencies.
package chtih_pkg;

	localparam int MASK_W  = 32;
	localparam int TS_W    = 64;
	localparam int WIDTH_W = 32;
	localparam int CNT_W   = 32;
	localparam int FUNC_W  = 2;

	localparam logic [MASK_W-1:0]  MARKER_MASK   = 32'h8000_0000;
	localparam logic [WIDTH_W-1:0] DEFAULT_WIDTH = 32'd1_000_000;
	localparam logic [CNT_W-1:0]   CNT_MAX       = '1;

	localparam logic [FUNC_W-1:0] FN_HIT   = 2'd0;
	localparam logic [FUNC_W-1:0] FN_READ  = 2'd1;
	localparam logic [FUNC_W-1:0] FN_WIDTH = 2'd2;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SCAN,
		ST_DIVIDE,
		ST_BIN,
		ST_LOOKUP,
		ST_INC,
		ST_RD_LOOKUP,
		ST_RD_OUT
	} state_t;

endpackage

@@ sv/chtih_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module chtih_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

@@ sv/channel_time_interval_histogram.sv @@
// Top level of the per-channel time-interval histogram.
// Depends on chtih_pkg and the generic RAM chtih_ram.
//
// Usage: one input channel (in_valid/in_ready) carries a word with a function
// code. A hit event (func 0) files, for every set channel bit whose last hit
// is older, the interval since that hit into one of NUM_BINS bins or the
// overflow bin; a MARKER_MASK hit is dropped. A read (func 1) returns one
// word on the output channel (out_valid/out_ready) with the count of the
// addressed bin. A width write (func 2) sets a channel's bin width in ticks.
// Other codes are dropped. Processing: a width write is taken as the word is
// accepted; a read goes through ST_RD_LOOKUP and ST_RD_OUT to the output
// register. A hit event walks the channels up to the highest set bit and ends
// once the mask is empty; for each filed interval the restoring divider
// retires one quotient bit per cycle over the 64-bit interval (skipped at zero
// width), then the saturating count is read and rewritten in the histogram RAM.
// Reset: the histogram RAM is swept to zero, one entry per cycle, over all
// NUM_CHANNELS*(NUM_BINS+1) entries; in_ready stays low until the sweep is
// done. Bin widths return to 1000000 and all hit history is lost.
// Stall: a read result waits in the output register; new words are still
// accepted, but a second read waits until the first result has been taken.
module channel_time_interval_histogram
	import chtih_pkg::*;
#(
	parameter int NUM_CHANNELS = 12,
	parameter int NUM_BINS = 100,
	localparam int CHW = $clog2(NUM_CHANNELS + 1),
	localparam int BIW = $clog2(NUM_BINS + 1)
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [FUNC_W-1:0]  func,
	input  logic [MASK_W-1:0]  channel_mask,
	input  logic [TS_W-1:0]    timestamp,
	input  logic [CHW-1:0]     channel,
	input  logic [BIW-1:0]     bin_index,
	input  logic [WIDTH_W-1:0] width_value,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [CNT_W-1:0]   bin_count
);

	// Geometry of the histogram store: one row of NUM_BINS+1 counters per channel.
	localparam int SLOTS = NUM_BINS + 1;
	localparam int DEPTH = NUM_CHANNELS * SLOTS;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CIW   = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
	localparam int STW   = $clog2(TS_W + 1);
	localparam int REMW  = WIDTH_W;

	state_t state_q, state_d;

	// Per-channel state. Last hit times are only read once the seen bit is set.
	logic [TS_W-1:0]         last_q  [NUM_CHANNELS];
	logic [WIDTH_W-1:0]      width_q [NUM_CHANNELS];
	logic [NUM_CHANNELS-1:0] seen_q;

	// Event being walked: the mask shifts right so bit 0 is always the current channel.
	logic [NUM_CHANNELS-1:0] mask_q;
	logic [TS_W-1:0]         ts_q;
	logic [CIW-1:0]          chan_q;

	// Bit-serial divider. dvd_q shifts the interval out at the top and takes
	// quotient bits in at the bottom, so it ends up holding the quotient.
	logic [TS_W-1:0]    dvd_q;
	logic [REMW-1:0]    rem_q;
	logic [WIDTH_W-1:0] dsr_q;
	logic [STW-1:0]     step_q;
	logic               zero_w_q;

	logic [AW-1:0]    addr_q;
	logic [AW-1:0]    clr_q;
	logic             rd_oor_q;
	logic             out_valid_q;
	logic [CNT_W-1:0] bin_count_q;

	// RAM port signals.
	logic             ram_wr_en;
	logic [AW-1:0]    ram_wr_addr;
	logic [CNT_W-1:0] ram_wr_data;
	logic             ram_rd_en;
	logic [CNT_W-1:0] ram_rd_data;

	logic           accept;
	logic [CIW-1:0] cur;
	logic           file_now;
	logic [REMW:0]  trial;
	logic [REMW:0]  trial_diff;
	logic           trial_ge;
	logic [BIW-1:0] slot;
	logic           rd_in_range;
	logic           wr_in_range;
	logic           out_load;

	assign accept = in_valid && in_ready;
	assign cur    = chan_q;

	// A channel files an interval only when it has history and time moved forward.
	assign file_now = mask_q[0] && seen_q[cur] && (ts_q > last_q[cur]);

	// One restoring-division step: bring down the next interval bit and try a subtract.
	assign trial      = {rem_q, dvd_q[TS_W-1]};
	assign trial_diff = trial - {1'b0, dsr_q};
	assign trial_ge   = (trial >= {1'b0, dsr_q});

	// Zero width and any quotient of NUM_BINS or more land in the overflow bin.
	assign slot = (zero_w_q || (dvd_q >= TS_W'(NUM_BINS))) ? BIW'(NUM_BINS) : dvd_q[BIW-1:0];

	assign rd_in_range = (channel < CHW'(NUM_CHANNELS)) && (bin_index <= BIW'(NUM_BINS));
	assign wr_in_range = (channel < CHW'(NUM_CHANNELS));

	// Next state and control.
	always_comb begin
		state_d     = state_q;
		in_ready    = 1'b0;
		ram_wr_en   = 1'b0;
		ram_wr_addr = addr_q;
		ram_wr_data = '0;
		ram_rd_en   = 1'b0;
		out_load    = 1'b0;
		unique case (state_q)
			ST_CLEAR: begin
				ram_wr_en   = 1'b1;
				ram_wr_addr = clr_q;
				if (clr_q == AW'(DEPTH - 1)) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					unique case (func)
						FN_HIT: begin
							if (channel_mask != MARKER_MASK) begin
								state_d = ST_SCAN;
							end
						end
						FN_READ: state_d = ST_RD_LOOKUP;
						default: state_d = ST_IDLE;
					endcase
				end
			end
			ST_SCAN: begin
				if (mask_q == '0) begin
					state_d = ST_IDLE;
				end else if (file_now) begin
					state_d = (width_q[cur] == '0) ? ST_BIN : ST_DIVIDE;
				end
			end
			ST_DIVIDE: begin
				if (step_q == STW'(1)) begin
					state_d = ST_BIN;
				end
			end
			ST_BIN: state_d = ST_LOOKUP;
			ST_LOOKUP: begin
				ram_rd_en = 1'b1;
				state_d   = ST_INC;
			end
			ST_INC: begin
				ram_wr_en   = 1'b1;
				ram_wr_data = (ram_rd_data == CNT_MAX) ? ram_rd_data : ram_rd_data + 1'b1;
				state_d     = ST_SCAN;
			end
			ST_RD_LOOKUP: begin
				ram_rd_en = 1'b1;
				state_d   = ST_RD_OUT;
			end
			ST_RD_OUT: begin
				// The RAM holds its read data until the output register is free.
				if (!out_valid_q || out_ready) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// Control registers with reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q       <= '0;
			seen_q      <= '0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < NUM_CHANNELS; i++) begin
				width_q[i] <= DEFAULT_WIDTH;
			end
		end else begin
			if (state_q == ST_CLEAR) begin
				clr_q <= clr_q + 1'b1;
			end
			if (accept && (func == FN_WIDTH) && wr_in_range) begin
				width_q[channel[CIW-1:0]] <= width_value;
			end
			if ((state_q == ST_SCAN) && mask_q[0]) begin
				seen_q[cur] <= 1'b1;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		if (accept && (func == FN_HIT)) begin
			mask_q <= channel_mask[NUM_CHANNELS-1:0];
			ts_q   <= timestamp;
			chan_q <= '0;
		end
		if (accept && (func == FN_READ)) begin
			addr_q   <= AW'(channel[CIW-1:0]) * AW'(SLOTS) + AW'(bin_index);
			rd_oor_q <= !rd_in_range;
		end
		if ((state_q == ST_SCAN) && (mask_q != '0)) begin
			if (mask_q[0]) begin
				last_q[cur] <= ts_q;
			end
			if (file_now) begin
				dvd_q    <= ts_q - last_q[cur];
				dsr_q    <= width_q[cur];
				zero_w_q <= (width_q[cur] == '0);
				rem_q    <= '0;
				step_q   <= STW'(TS_W);
			end else begin
				mask_q <= mask_q >> 1;
				chan_q <= chan_q + 1'b1;
			end
		end
		if (state_q == ST_DIVIDE) begin
			rem_q  <= trial_ge ? trial_diff[REMW-1:0] : trial[REMW-1:0];
			dvd_q  <= {dvd_q[TS_W-2:0], trial_ge};
			step_q <= step_q - 1'b1;
		end
		if (state_q == ST_BIN) begin
			addr_q <= AW'(cur) * AW'(SLOTS) + AW'(slot);
		end
		if (state_q == ST_INC) begin
			mask_q <= mask_q >> 1;
			chan_q <= chan_q + 1'b1;
		end
		if (out_load) begin
			bin_count_q <= rd_oor_q ? '0 : ram_rd_data;
		end
	end

	chtih_ram #(
		.WIDTH(CNT_W),
		.DEPTH(DEPTH)
	) u_hist_ram (
		.clk    (clk),
		.wr_en  (ram_wr_en),
		.wr_addr(ram_wr_addr),
		.wr_data(ram_wr_data),
		.rd_en  (ram_rd_en),
		.rd_addr(addr_q),
		.rd_data(ram_rd_data)
	);

	assign out_valid = out_valid_q;
	assign bin_count = bin_count_q;

endmodule
